// ===== design/assert_macros.svh =====
// Assertion macros shared by the ordered list RTL.
// Depends on clk and rst_n being visible in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/olwd_pkg.sv =====
// Types, constants and slot arithmetic for the ordered list with delete.
// No dependencies; used by olwd_ram and ordered_list_with_delete.
package olwd_pkg;

  localparam int CAPACITY = 64;
  localparam int VAL_W    = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int SUM_W    = IDX_W + 1;

  typedef enum logic [1:0] {
    REQ_PREPEND = 2'd0,
    REQ_APPEND  = 2'd1,
    REQ_DELETE  = 2'd2,
    REQ_SHIFT   = 2'd3
  } req_t;

  typedef struct packed {
    req_t             req_type;
    logic [VAL_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [VAL_W-1:0] front_value;
    logic             done_res;
    logic [CNT_W-1:0] count;
    logic             is_empty;
    logic             is_full;
  } out_word_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [VAL_W-1:0] data;
  } ram_wr_t;

  // Ring slot of list position pos; base + pos stays below twice the capacity.
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                               input logic [CNT_W-1:0] pos);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(pos);
    if (sum >= SUM_W'(CAPACITY)) begin
      sum = sum - SUM_W'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

// ===== design/olwd_ram.sv =====
// Entry store of the ordered list: one write port, one registered read port.
// Depends on olwd_pkg for the depth, widths and write word type.
module olwd_ram (
  input  logic                          clk,
  input  olwd_pkg::ram_wr_t             wr,
  input  logic [olwd_pkg::IDX_W-1:0]    rd_addr,
  output logic [olwd_pkg::VAL_W-1:0]    rd_data
);
  import olwd_pkg::*;

  logic [VAL_W-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/ordered_list_with_delete.sv =====
// Bounded ordered list of 16-bit values kept in a ring memory with a front pointer and a count.
// Prepend, append and shift are accepted in ST_IDLE, where the front slot is read, and finish in
// ST_START, where the ring is updated through the single read and single write port of the entry
// memory. A delete scans from the front in ST_SCAN; nothing must move when the match is the front
// or last entry or there is no match, else later entries move one slot toward the front in
// ST_MOVE, one entry per cycle. A result waits in the output register, and the next request is
// accepted while it waits; execution stalls only when a new result is ready before the previous
// one is taken. Depends on olwd_pkg and olwd_ram.
`include "assert_macros.svh"

module ordered_list_with_delete (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  olwd_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output olwd_pkg::out_word_t  out_data
);
  import olwd_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_START = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_MOVE  = 5'b01000,
    ST_FIN   = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  req_t             req_r;
  logic [VAL_W-1:0] val_r;
  logic [IDX_W-1:0] front_r, front_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  out_word_t        res_r, res_comb;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_data_r, out_data_nxt;

  logic [IDX_W-1:0] rd_addr;
  logic [VAL_W-1:0] rd_data;
  ram_wr_t          wr;

  logic             fin, done_c, out_free, load, full, empty, accept;
  logic [VAL_W-1:0] fv_c;

  olwd_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid & in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;
  assign full      = (cnt_r == CNT_W'(CAPACITY));
  assign empty     = (cnt_r == '0);

  always_comb begin
    state_nxt = state_r;
    front_nxt = front_r;
    cnt_nxt   = cnt_r;
    pos_nxt   = pos_r;
    fin       = 1'b0;
    done_c    = 1'b0;
    fv_c      = '0;
    wr        = '0;
    rd_addr   = front_r;
    case (state_r)
      ST_IDLE: begin
        // read the front slot now so a shift has it next cycle
        if (accept) begin
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        case (req_r)
          REQ_PREPEND: begin
            fin = 1'b1;
            if (!full) begin
              front_nxt = (front_r == '0) ? IDX_W'(CAPACITY - 1) : front_r - IDX_W'(1);
              wr.en     = 1'b1;
              wr.addr   = front_nxt;
              wr.data   = val_r;
              cnt_nxt   = cnt_r + CNT_W'(1);
              done_c    = 1'b1;
            end
          end
          REQ_APPEND: begin
            fin = 1'b1;
            if (!full) begin
              wr.en   = 1'b1;
              wr.addr = slot_of(front_r, cnt_r);
              wr.data = val_r;
              cnt_nxt = cnt_r + CNT_W'(1);
              done_c  = 1'b1;
            end
          end
          REQ_DELETE: begin
            if (empty) begin
              fin = 1'b1;
            end else begin
              rd_addr   = front_r;
              pos_nxt   = '0;
              state_nxt = ST_SCAN;
            end
          end
          REQ_SHIFT: begin
            fin = 1'b1;
            if (!empty) begin
              fv_c      = rd_data;
              front_nxt = slot_of(front_r, CNT_W'(1));
              cnt_nxt   = cnt_r - CNT_W'(1);
              done_c    = 1'b1;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      ST_SCAN: begin
        // rd_data holds position pos_r; fetch the next one
        rd_addr = slot_of(front_r, pos_r + CNT_W'(1));
        if (rd_data == val_r) begin
          done_c = 1'b1;
          if (pos_r == '0) begin
            front_nxt = slot_of(front_r, CNT_W'(1));
            cnt_nxt   = cnt_r - CNT_W'(1);
            fin       = 1'b1;
          end else if (pos_r + CNT_W'(1) == cnt_r) begin
            cnt_nxt = cnt_r - CNT_W'(1);
            fin     = 1'b1;
          end else begin
            state_nxt = ST_MOVE;
          end
        end else if (pos_r + CNT_W'(1) == cnt_r) begin
          fin = 1'b1;
        end else begin
          pos_nxt = pos_r + CNT_W'(1);
        end
      end
      ST_MOVE: begin
        // rd_data holds position pos_r + 1; pull it down into pos_r
        rd_addr = slot_of(front_r, pos_r + CNT_W'(2));
        wr.en   = 1'b1;
        wr.addr = slot_of(front_r, pos_r);
        wr.data = rd_data;
        if (pos_r + CNT_W'(2) == cnt_r) begin
          cnt_nxt = cnt_r - CNT_W'(1);
          done_c  = 1'b1;
          fin     = 1'b1;
        end else begin
          pos_nxt = pos_r + CNT_W'(1);
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (fin) begin
      state_nxt = out_free ? ST_IDLE : ST_FIN;
    end
  end

  always_comb begin
    res_comb.front_value = fv_c;
    res_comb.done_res    = done_c;
    res_comb.count       = cnt_nxt;
    res_comb.is_empty    = (cnt_nxt == '0);
    res_comb.is_full     = (cnt_nxt == CNT_W'(CAPACITY));
  end

  assign load          = (fin || (state_r == ST_FIN)) && out_free;
  assign out_data_nxt  = fin ? res_comb : res_r;
  assign out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      front_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    if (accept) begin
      req_r <= in_data.req_type;
      val_r <= in_data.value;
    end
    if (fin) begin
      res_r <= res_comb;
    end
    if (load) begin
      out_data_r <= out_data_nxt;
    end
  end

  `ASSERT_CLK(a_cnt_bound, cnt_r <= CNT_W'(CAPACITY), "count above capacity")
  `ASSERT_CLK(a_front_bound, SUM_W'(front_r) < SUM_W'(CAPACITY), "front pointer out of ring")
  `ASSERT_CLK(a_move_span, (state_r == ST_MOVE) |-> ((pos_r + CNT_W'(2)) <= cnt_r), "compaction past tail")
  `ASSERT_CLK(a_quiet_write, ((state_r == ST_IDLE) || (state_r == ST_FIN)) |-> !wr.en, "entry written while not executing")

endmodule
